### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator.
// Holds the request and response item structs, the status codes, the table entry struct and the split slack.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int unsigned SplitSlack = 16;

   typedef enum logic [0:0] {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_SIZE = 3'd1,
      ST_NO_FIT    = 3'd2,
      ST_NULL_FREE = 3'd3,
      ST_UNKNOWN   = 3'd4
   } status_type;

   typedef struct packed {
      logic [0:0]  req_type;
      logic [20:0] request_bytes;
      logic [19:0] release_offset;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [19:0] payload_offset;
   } rsp_item_type;

   // One table entry as held in the segment memory.
   typedef struct packed {
      logic [19:0] start;
      logic [19:0] payload;
      logic        is_free;
   } seg_entry_type;

endpackage

### rtl/ffba_seg_mem.sv
// ----------------------------------------------------------------------------
// ffba_seg_mem: segment table memory.
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffba_seg_mem
   import ffba_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  seg_entry_type wr_data,
   input  logic [AW-1:0] rd_addr,
   output seg_entry_type rd_data
);

   seg_entry_type mem_ff [DEPTH];
   seg_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

### rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator with split and merge.
// Keeps an address-ordered block table in one synchronous memory.
// ----------------------------------------------------------------------------
// Zero-size allocations and null frees answer from idle without a table scan. The
// scan reads one table entry per cycle; a split or merge then shifts the table
// tail one entry at a time, read then write, through the single memory port pair.
// Throughput: one item at a time; busy is high while the sequencer is out of idle
// and falls as the strobe rises; it stays low for zero-size allocations and null frees.
// Reset: synchronous; it restores a single free block covering the heap,
// written into entry 0 as the sequencer leaves reset, with count_ff at one.
// The receiver cannot stall: rsp_valid is high for exactly one cycle.
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int unsigned HEAP_BYTES   = 1048576,
   parameter int unsigned HEADER_BYTES = 24,
   parameter int unsigned MAX_SEGMENTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [19:0] Hdr = 20'(HEADER_BYTES);
   localparam logic [19:0] InitPay = 20'(HEAP_BYTES - HEADER_BYTES);
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);

   // INIT writes entry 0. SCAN walks entries (read address leads data by one).
   // UP_RD/UP_WR move entries up for a split, DN_RD/DN_WR move them down for a merge.
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_GRANT, S_UP_RD, S_UP_WR, S_SPLIT_WR,
      S_FREE_CHK, S_PREV_RD, S_PREV_CHK, S_DN_RD, S_DN_WR, S_DONE
   } state_type;

   state_type      state_ff;
   req_item_type   req_ff;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  idx_ff;      // entry under scan whose data arrives now
   logic [CW-1:0]  ptr_ff;      // shift pointer
   logic [CW-1:0]  hit_ff;      // found entry
   logic [CW-1:0]  kmerge_ff;   // entry that absorbs its successor
   logic           pend_prev_ff; // after a merge with next, try the previous
   seg_entry_type  hit_e_ff;    // found entry, marked allocated, to write back
   seg_entry_type  acc_ff;      // absorbing entry, or the split-off remainder
   logic [2:0]     status_ff;
   logic [19:0]    offset_ff;
   logic           rsp_ff;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   seg_entry_type  wr_data, rd_data;

   ffba_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Fit tests at full width.
   logic [21:0] need;
   logic [22:0] split_need;
   assign need       = {1'b0, req_ff.request_bytes} + 22'(HEADER_BYTES);
   assign split_need = {1'b0, need} + 23'(HEADER_BYTES + SplitSlack);

   logic fits, can_split, addr_hit;
   assign fits      = rd_data.is_free && ({2'b00, rd_data.payload} >= need);
   assign can_split = ({3'b000, rd_data.payload} >= split_need) && (count_ff < MaxCnt);
   assign addr_hit  = (rd_data.start + Hdr) == req_ff.release_offset;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_ff;
   assign rsp_item  = '{status: status_ff, payload_offset: offset_ff};

   // Memory port control, driven from state.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(0);
      wr_data = rd_data;
      rd_addr = AW'(0);
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_data = '{start: 20'd0, payload: InitPay, is_free: 1'b1};
         end
         S_IDLE:  rd_addr = AW'(0);
         S_SCAN:  rd_addr = AW'(idx_ff + 1'b1);
         S_UP_RD: rd_addr = AW'(ptr_ff - 1'b1);
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff);
         end
         S_SPLIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(hit_ff + 1'b1);
            wr_data = acc_ff;
         end
         S_GRANT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(hit_ff);
            wr_data = hit_e_ff;
         end
         S_FREE_CHK: rd_addr = AW'(0);
         S_PREV_RD:  rd_addr = AW'(kmerge_ff - 1'b1);
         S_DN_RD:    rd_addr = AW'(ptr_ff + 1'b1);
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff);
         end
         S_DONE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(kmerge_ff);
            wr_data = acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= CW'(1);
         rsp_ff   <= 1'b0;
      end else begin
         rsp_ff <= 1'b0;
         case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: begin
               if (start) begin
                  req_ff    <= req_item;
                  idx_ff    <= '0;
                  offset_ff <= 20'd0;
                  if (req_item.req_type == REQ_ALLOC && req_item.request_bytes == 21'd0) begin
                     status_ff <= ST_ZERO_SIZE;
                     rsp_ff    <= 1'b1;
                  end else if (req_item.req_type == REQ_FREE &&
                               req_item.release_offset == 20'd0) begin
                     status_ff <= ST_NULL_FREE;
                     rsp_ff    <= 1'b1;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (req_ff.req_type == REQ_ALLOC && fits) begin
                  hit_ff    <= idx_ff;
                  // A split block keeps exactly the requested payload.
                  hit_e_ff  <= '{start: rd_data.start,
                                 payload: can_split ? req_ff.request_bytes[19:0]
                                                    : rd_data.payload,
                                 is_free: 1'b0};
                  // The remainder of a split, taken from the original payload.
                  acc_ff    <= '{start: rd_data.start + 20'(need),
                                 payload: rd_data.payload - 20'(need), is_free: 1'b1};
                  status_ff <= ST_OK;
                  offset_ff <= rd_data.start + Hdr;
                  if (can_split) begin
                     ptr_ff   <= count_ff;
                     count_ff <= count_ff + 1'b1;
                     state_ff <= (count_ff > idx_ff + 1'b1) ? S_UP_RD : S_SPLIT_WR;
                  end else begin
                     state_ff <= S_GRANT;
                  end
               end else if (req_ff.req_type == REQ_FREE && addr_hit) begin
                  hit_ff    <= idx_ff;
                  acc_ff    <= '{start: rd_data.start, payload: rd_data.payload,
                                 is_free: 1'b1};
                  kmerge_ff <= idx_ff;
                  status_ff <= ST_OK;
                  state_ff  <= (idx_ff + 1'b1 < count_ff) ? S_FREE_CHK : S_PREV_RD;
                  pend_prev_ff <= (idx_ff != '0);
               end else if (idx_ff + 1'b1 >= count_ff) begin
                  status_ff <= (req_ff.req_type == REQ_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
                  rsp_ff    <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            // Split: move entries [hit+1, count) up by one, top first.
            S_UP_RD: state_ff <= S_UP_WR;
            S_UP_WR: begin
               ptr_ff   <= ptr_ff - 1'b1;
               state_ff <= (ptr_ff - 1'b1 > hit_ff + 1'b1) ? S_UP_RD : S_SPLIT_WR;
            end
            S_SPLIT_WR: state_ff <= S_GRANT;
            S_GRANT: begin
               rsp_ff   <= 1'b1;
               state_ff <= S_IDLE;
            end
            // Free: rd_data holds entry hit+1 (read during the scan step).
            S_FREE_CHK: begin
               if (rd_data.is_free) begin
                  acc_ff.payload <= acc_ff.payload + Hdr + rd_data.payload;
                  ptr_ff   <= hit_ff + 1'b1;
                  state_ff <= (hit_ff + 2'd2 < count_ff) ? S_DN_RD : S_DONE;
                  count_ff <= count_ff - 1'b1;
               end else begin
                  state_ff <= S_PREV_RD;
               end
            end
            S_PREV_RD: begin
               // Read the previous entry when a merge with it is still pending.
               if (pend_prev_ff) begin
                  kmerge_ff <= kmerge_ff - 1'b1;
                  state_ff  <= S_PREV_CHK;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_PREV_CHK: begin
               // rd_data is entry kmerge (hit-1); acc is entry hit, merged with its successor if that was free.
               pend_prev_ff <= 1'b0;
               if (rd_data.is_free) begin
                  acc_ff   <= '{start: rd_data.start,
                                payload: rd_data.payload + Hdr + acc_ff.payload,
                                is_free: 1'b1};
                  ptr_ff   <= hit_ff;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= (hit_ff + 1'b1 < count_ff) ? S_DN_RD : S_DONE;
               end else begin
                  kmerge_ff <= hit_ff;
                  state_ff  <= S_DONE;
               end
            end
            // Merge: move entries down by one from ptr upward.
            S_DN_RD: state_ff <= S_DN_WR;
            S_DN_WR: begin
               ptr_ff <= ptr_ff + 1'b1;
               state_ff <= (ptr_ff + 1'b1 < count_ff) ? S_DN_RD : S_DONE;
            end
            S_DONE: begin
               if (pend_prev_ff) begin
                  state_ff <= S_PREV_RD;
               end else begin
                  rsp_ff   <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
